// ===== rtl/mrle_pkg.sv =====
package mrle_pkg;

    // Bytes that one plane covers before it ends.
    localparam int unsigned FRAME_BYTES = 512;
    localparam int unsigned CNT_W       = 10;

    // Depth of the event queue between the parser and the output stage.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] TOK_ZERO   = 8'hEE;
    localparam logic [7:0] TOK_REPEAT = 8'hED;
    localparam logic [7:0] METHOD_OK  = 8'h01;

    // Result status codes.
    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_ERROR  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    typedef enum logic [1:0] {
        EV_RUN,
        EV_ERROR,
        EV_EMPTY
    } t_ev_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] run_value;
        logic [7:0] run_length;
        logic       image_done;
    } t_out_item;

    // Classified event handed from the parser to the output stage.
    typedef struct packed {
        t_ev_kind   kind;
        logic [7:0] value;
        logic [7:0] length;
        logic [7:0] plane;
        logic       done;
    } t_event;

endpackage

// ===== rtl/mrle_front.sv =====
module mrle_front
    import mrle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_space,
    output logic     o_ready,
    output logic     o_push,
    output t_event   o_ev
);

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_METHOD,
        PH_TOKEN,
        PH_ZCOUNT,
        PH_RVALUE,
        PH_RCOUNT,
        PH_IDLE
    } t_phase;

    localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(FRAME_BYTES);

    t_phase           r_phase, n_phase, ph;
    logic [7:0]       r_plane_total, n_plane_total;
    logic [7:0]       r_plane_index, n_plane_index;
    logic [CNT_W-1:0] r_bytes_done, n_bytes_done;
    logic [7:0]       r_repeat_value, n_repeat_value;

    logic             accept;
    logic             acc_go;
    logic [7:0]       acc_val, acc_len, next_index;
    logic [CNT_W-1:0] sum;
    logic             plane_end, img_end;
    logic [7:0]       b;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign b       = i_item.in_byte;

    assign sum        = r_bytes_done + CNT_W'(acc_len);
    assign plane_end  = (sum >= FRAME_LIMIT);
    assign next_index = r_plane_index + 8'd1;
    assign img_end    = plane_end && (next_index >= r_plane_total);

    always_comb begin
        ph             = i_item.frame_start ? PH_COUNT : r_phase;
        n_phase        = r_phase;
        n_plane_total  = r_plane_total;
        n_plane_index  = r_plane_index;
        n_bytes_done   = r_bytes_done;
        n_repeat_value = i_item.frame_start ? 8'd0 : r_repeat_value;
        acc_go         = 1'b0;
        acc_val        = b;
        acc_len        = 8'd1;
        o_push         = 1'b0;
        o_ev           = '{kind: EV_RUN, value: 8'd0, length: 8'd0,
                           plane: r_plane_index, done: 1'b0};

        unique case (ph)
            PH_COUNT: begin
                n_plane_total = b;
                n_plane_index = 8'd0;
                n_bytes_done  = '0;
                if (b == 8'd0) begin
                    n_phase     = PH_IDLE;
                    o_push      = 1'b1;
                    o_ev.kind   = EV_EMPTY;
                    o_ev.done   = 1'b1;
                end else begin
                    n_phase = PH_METHOD;
                end
            end
            PH_METHOD: begin
                n_bytes_done = '0;
                if (b == METHOD_OK) begin
                    n_phase = PH_TOKEN;
                end else begin
                    n_phase   = PH_IDLE;
                    o_push    = 1'b1;
                    o_ev.kind = EV_ERROR;
                    o_ev.done = 1'b1;
                end
            end
            PH_TOKEN: begin
                if (b == TOK_ZERO) begin
                    n_phase = PH_ZCOUNT;
                end else if (b == TOK_REPEAT) begin
                    n_phase = PH_RVALUE;
                end else begin
                    acc_go = 1'b1;
                end
            end
            PH_ZCOUNT: begin
                acc_go  = 1'b1;
                acc_val = 8'd0;
                acc_len = b;
            end
            PH_RVALUE: begin
                n_repeat_value = b;
                n_phase        = PH_RCOUNT;
            end
            PH_RCOUNT: begin
                acc_go  = 1'b1;
                acc_val = r_repeat_value;
                acc_len = b;
            end
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Account a run against the plane and close it once the frame is covered.
        if (acc_go) begin
            o_push      = 1'b1;
            o_ev.kind   = EV_RUN;
            o_ev.value  = acc_val;
            o_ev.length = acc_len;
            o_ev.done   = img_end;
            if (plane_end) begin
                n_bytes_done  = '0;
                n_plane_index = next_index;
                n_phase       = img_end ? PH_IDLE : PH_METHOD;
            end else begin
                n_bytes_done = sum;
                n_phase      = PH_TOKEN;
            end
        end

        // Push only for a byte that is taken this cycle.
        o_push = o_push && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_COUNT;
            r_plane_total  <= 8'd0;
            r_plane_index  <= 8'd0;
            r_bytes_done   <= '0;
            r_repeat_value <= 8'd0;
        end else if (accept) begin
            r_phase        <= n_phase;
            r_plane_total  <= n_plane_total;
            r_plane_index  <= n_plane_index;
            r_bytes_done   <= n_bytes_done;
            r_repeat_value <= n_repeat_value;
        end
    end

endmodule

// ===== rtl/mrle_queue.sv =====
module mrle_queue
    import mrle_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_ev,
    output logic   o_space,
    output logic   o_valid,
    input  logic   i_pop,
    output t_event o_ev
);

    t_event             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_space = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_ev    = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/mrle_back.sv =====
module mrle_back
    import mrle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_event    i_ev,
    output logic      o_pop,
    input  logic [7:0] i_plane_select,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic      r_valid;
    t_out_item r_out, n_out;
    logic      emit;

    assign o_pop       = i_q_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    always_comb begin
        emit  = 1'b0;
        n_out = '{status: ST_FINISH, run_value: 8'd0, run_length: 8'd0, image_done: 1'b1};
        unique case (i_ev.kind)
            EV_RUN: begin
                if ((i_ev.plane == i_plane_select) && (i_ev.length != 8'd0)) begin
                    emit             = 1'b1;
                    n_out.status     = ST_RUN;
                    n_out.run_value  = i_ev.value;
                    n_out.run_length = i_ev.length;
                    n_out.image_done = i_ev.done;
                end else begin
                    // Unselected or empty run: report only the image end.
                    emit = i_ev.done;
                end
            end
            EV_ERROR: begin
                emit         = 1'b1;
                n_out.status = ST_ERROR;
            end
            EV_EMPTY: begin
                emit = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= emit;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/multiplane_rle_image_decoder.sv =====
// Multiplane run-length image decoder.
//
// Input channel (i_in_valid / o_in_ready / i_in): one compressed byte per item,
// with frame_start marking the first byte of an image (the plane count byte).
// Output channel (o_out_valid / i_out_ready / o_out): run descriptors of the
// selected plane, plus an error item for a bad method byte and a finish item
// when an image has no planes or ends on a run that is not reported.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): plane_select, always
// ready; write it only while the decoder is idle.
//
// Throughput: one byte per cycle while the queue has space. The parser steps
// its state machine in the cycle the byte is accepted and pushes any event it
// makes into a four-entry queue; the output stage pops one event per cycle,
// while its output register is empty or being taken, into that register.
// When the receiver stalls, the output register holds and the queue fills;
// o_in_ready drops only once all four queue entries are taken.
// Reset: queue and output register empty, parser waiting for the plane count,
// plane_select set to 1.
module multiplane_rle_image_decoder
    import mrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_plane_select;
    logic       q_space, q_valid, q_pop, f_push;
    t_event     f_ev, q_ev;

    // Config is always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_select <= 8'd1;
        end else if (i_cfg_valid) begin
            r_plane_select <= i_cfg_data;
        end
    end

    // Parse bytes and classify them into run / error / empty-image events.
    mrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in),
        .i_space (q_space),
        .o_ready (o_in_ready),
        .o_push  (f_push),
        .o_ev    (f_ev)
    );

    // Decouple the parser from a stalled receiver.
    mrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_ev    (f_ev),
        .o_space (q_space),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_ev    (q_ev)
    );

    // Filter by plane and format the result item.
    mrle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_ev           (q_ev),
        .o_pop          (q_pop),
        .i_plane_select (r_plane_select),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out)
    );

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == ST_RUN || o_out.status == ST_ERROR ||
                         o_out.status == ST_FINISH))
        else $error("illegal result status");

    a_nonrun_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_RUN) |->
            (o_out.run_length == 8'd0 && o_out.run_value == 8'd0 && o_out.image_done))
        else $error("status item must carry zero run and end the image");

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_RUN) |-> (o_out.run_length != 8'd0))
        else $error("empty run emitted");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

// ===== tb/sv/mrle_run_checker.sv =====
module mrle_run_checker
    import mrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        DP_COUNT,
        DP_METHOD,
        DP_TOKEN,
        DP_ZCOUNT,
        DP_RVALUE,
        DP_RCOUNT,
        DP_IDLE
    } t_dec_phase;

    t_dec_phase       dec_phase;
    logic [7:0]       planes_in_image;
    logic [7:0]       cur_plane;
    logic [CNT_W-1:0] plane_fill;
    logic [7:0]       held_value;
    logic [7:0]       sel_plane;

    t_out_item   expected_runs[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned pending_count;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_count;
    assign o_results    = results_seen;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic clear_decoder();
        dec_phase       = DP_COUNT;
        planes_in_image = '0;
        cur_plane       = '0;
        plane_fill      = '0;
        held_value      = '0;
    endtask

    task automatic push_status(input logic [1:0] st);
        expected_runs.push_back(t_out_item'{status: st, run_value: 8'd0,
                                            run_length: 8'd0, image_done: 1'b1});
    endtask

    // Account a run against the plane; a run may overshoot the frame size.
    task automatic close_run(input logic [7:0] value, input logic [7:0] len);
        logic emit;
        logic last;
        emit = (cur_plane == sel_plane) && (len != 8'd0);
        last = 1'b0;
        plane_fill = plane_fill + CNT_W'(len);
        if (plane_fill >= FRAME_BYTES) begin
            plane_fill = '0;
            cur_plane  = cur_plane + 8'd1;
            if (cur_plane >= planes_in_image) begin
                dec_phase = DP_IDLE;
                last      = 1'b1;
            end else begin
                dec_phase = DP_METHOD;
            end
        end else begin
            dec_phase = DP_TOKEN;
        end
        if (emit) begin
            expected_runs.push_back(t_out_item'{status: ST_RUN, run_value: value,
                                                run_length: len, image_done: last});
        end else if (last) begin
            push_status(ST_FINISH);
        end
    endtask

    task automatic decode_byte(input t_in_item it);
        if (it.frame_start) begin
            clear_decoder();
        end
        case (dec_phase)
            DP_COUNT: begin
                planes_in_image = it.in_byte;
                cur_plane       = '0;
                plane_fill      = '0;
                if (it.in_byte == 8'd0) begin
                    dec_phase = DP_IDLE;
                    push_status(ST_FINISH);
                end else begin
                    dec_phase = DP_METHOD;
                end
            end
            DP_METHOD: begin
                plane_fill = '0;
                if (it.in_byte == METHOD_OK) begin
                    dec_phase = DP_TOKEN;
                end else begin
                    dec_phase = DP_IDLE;
                    push_status(ST_ERROR);
                end
            end
            DP_TOKEN: begin
                if (it.in_byte == TOK_ZERO) begin
                    dec_phase = DP_ZCOUNT;
                end else if (it.in_byte == TOK_REPEAT) begin
                    dec_phase = DP_RVALUE;
                end else begin
                    close_run(it.in_byte, 8'd1);
                end
            end
            DP_ZCOUNT: begin
                close_run(8'd0, it.in_byte);
            end
            DP_RVALUE: begin
                held_value = it.in_byte;
                dec_phase  = DP_RCOUNT;
            end
            DP_RCOUNT: begin
                close_run(held_value, it.in_byte);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_runs.size() == 0) begin
            report_mismatch("result with nothing expected, status", got.status, -1);
        end else begin
            want = expected_runs.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.run_value !== want.run_value)
                report_mismatch("run_value", got.run_value, want.run_value);
            if (got.run_length !== want.run_length)
                report_mismatch("run_length", got.run_length, want.run_length);
            if (got.image_done !== want.image_done)
                report_mismatch("image_done", got.image_done, want.image_done);
        end
    endtask

    // Retire results before predicting from a byte taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            sel_plane = 8'd1;
            expected_runs.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result(i_out);
            if (i_cfg_valid && i_cfg_ready)
                sel_plane = i_cfg_data;
            if (i_in_valid && i_in_ready)
                decode_byte(i_in);
        end
        pending_count = expected_runs.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top
    import mrle_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let the pipeline settle after the last expected result.
    localparam int unsigned SETTLE_CYCLES = 8;
    // Cycles with no item moved on any channel before the run is abandoned.
    localparam int unsigned STALL_LIMIT   = 2000;
    // Image bytes, stray bytes not counted, per plane_select setting.
    localparam int unsigned SEG_BYTES     = 62;
    localparam int unsigned NUM_SEGS      = 9;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_checked;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned stall_cycles;
    int unsigned sent_bytes;
    int unsigned noise_bytes;
    int unsigned images_sent;
    int unsigned cfg_writes;

    multiplane_rle_image_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    mrle_run_checker u_run_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: stall at random at the current idle rate, never when it is zero.
    always @(posedge i_clk) begin
        if (rx_idle_pct == 0)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Count cycles in which no item moves on any channel; any handshake clears it.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one byte. Optionally idle first, then hold valid and payload until
    // the item is taken. Ready is sampled at the falling edge, where it is stable.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        t_in_item it;
        bit       taken;
        it.in_byte     = b;
        it.frame_start = fs;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        sent_bytes++;
    endtask

    // Drop valid and hold off until every predicted result has come back,
    // then give the pipeline time to finish bytes that produce nothing.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_plane_select(input logic [7:0] sel);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sel;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [7:0] pick_plane_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'd0;
        if (r < 75)
            return 8'($urandom_range(1, 3));
        if (r < 92)
            return 8'($urandom_range(4, 6));
        if (r < 96)
            return 8'd255;
        return 8'($urandom_range(7, 254));
    endfunction

    // One image: plane count, then per plane a method byte and tokens until the
    // plane covers the frame. Occasionally break it off or spoil a method byte;
    // large plane counts always run on a token budget to keep the run bounded.
    task automatic send_image(input logic [7:0] planes);
        int unsigned fill;
        int unsigned budget;
        int unsigned pick;
        int          p;
        logic [7:0]  val;
        logic [7:0]  cnt;
        bit          cut;
        cut    = (planes > 8'd6) || ($urandom_range(0, 99) < 5);
        budget = $urandom_range(0, 40);
        images_sent++;
        send_byte(planes, 1'b1);
        for (p = 0; p < planes; p++) begin
            if ($urandom_range(0, 99) < 3) begin
                val = 8'($urandom_range(0, 255));
                if (val == METHOD_OK)
                    val = 8'h00;
                send_byte(val, 1'b0);
                return;
            end
            send_byte(METHOD_OK, 1'b0);
            fill = 0;
            while (fill < FRAME_BYTES) begin
                if (cut) begin
                    if (budget == 0)
                        return;
                    budget--;
                end
                pick = $urandom_range(0, 99);
                cnt  = 8'($urandom_range(0, 255));
                if (pick < 30) begin
                    // Literal: any byte other than the two escape codes.
                    do val = 8'($urandom_range(0, 255));
                    while (val == TOK_ZERO || val == TOK_REPEAT);
                    send_byte(val, 1'b0);
                    fill += 1;
                end else if (pick < 55) begin
                    send_byte(TOK_ZERO, 1'b0);
                    send_byte(cnt, 1'b0);
                    fill += cnt;
                end else begin
                    send_byte(TOK_REPEAT, 1'b0);
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    send_byte(cnt, 1'b0);
                    fill += cnt;
                end
            end
        end
    endtask

    // Stray bytes: one with frame_start starts a new image; others are ignored
    // after an image ends and otherwise extend a broken image.
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
            noise_bytes++;
        end
    endtask

    initial begin
        int unsigned seg;
        int unsigned seg_start;
        logic [7:0]  sel;

        tx_idle_pct  = 36;
        rx_idle_pct  = 45;
        sent_bytes   = 0;
        noise_bytes  = 0;
        images_sent  = 0;
        cfg_writes   = 0;
        stall_cycles = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with plane_select still at its reset value of 1.
        // First byte after reset without frame_start is still the plane count;
        // zero planes finish the image at once, then the next byte is ignored.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Bad method byte.
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b0);
        // Two planes. Plane 0 is not selected and ends on an overshooting run.
        send_byte(8'h02, 1'b1);
        send_byte(METHOD_OK, 1'b0);
        send_byte(TOK_REPEAT, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(TOK_ZERO, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(TOK_REPEAT, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h03, 1'b0);
        // Plane 1 is selected: literal, empty zero run, two full repeats and a
        // closing literal that lands exactly on the frame size.
        send_byte(METHOD_OK, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(TOK_ZERO, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(TOK_REPEAT, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(TOK_REPEAT, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Ignored after the image ends.
        send_byte(8'hA5, 1'b0);

        // Random part: one plane_select setting per segment, extremes included.
        // Idle rates swap after three segments and vanish for the last three.
        for (seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 3)
                0: begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 45;
                end
                1: begin
                    tx_idle_pct = 45;
                    rx_idle_pct = 36;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (seg)
                0:       sel = 8'd0;
                1:       sel = 8'd255;
                2:       sel = 8'd2;
                3:       sel = 8'($urandom_range(0, 3));
                4:       sel = 8'd1;
                6:       sel = 8'($urandom_range(0, 255));
                7:       sel = 8'd3;
                default: sel = 8'd0;
            endcase
            // Write the register only with the decoder quiet.
            drain_results();
            write_plane_select(sel);
            seg_start = sent_bytes - noise_bytes;
            while (sent_bytes - noise_bytes - seg_start < SEG_BYTES) begin
                send_image(pick_plane_count());
                if ($urandom_range(0, 99) < 25)
                    send_noise();
            end
        end

        drain_results();
        $display("Sent %0d bytes (%0d stray) in %0d images, %0d plane_select writes,",
                 sent_bytes, noise_bytes, images_sent, cfg_writes);
        $display("covering runs, bad methods, truncation and overshoot; %0d results checked.",
                 results_checked);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mrle_pkg.sv
rtl/mrle_front.sv
rtl/mrle_queue.sv
rtl/mrle_back.sv
rtl/multiplane_rle_image_decoder.sv
tb/sv/mrle_run_checker.sv
tb/sv/tb_top.sv
